@@ sv/ocf_rs_pkg.sv @@
// ============================================================================
// ocf_rs_pkg
// Shared types and constants for the control field report selector.
// ============================================================================
package ocf_rs_pkg;

    localparam int unsigned WORD_W     = 32;
    localparam int unsigned INTERVAL_W = 8;
    localparam int unsigned STREAK_W   = 8;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned PADDR_W    = 3;
    localparam int unsigned PDATA_W    = 32;

    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 8'd4;

    // status bits of the control word that force it out
    localparam logic [WORD_W-1:0] URGENT_FLAG_MASK = 32'h0000_3800;

    // register index taken from the word address
    localparam logic [PADDR_W-3:0] REG_REPORT_INTERVAL = 1'b0;

    typedef enum logic [1:0] {
        FUNC_SELECT  = 2'd0,
        FUNC_LATCH   = 2'd1,
        FUNC_CONFIRM = 2'd2,
        FUNC_NONE    = 2'd3
    } t_func;

    typedef struct packed {
        t_func             func;
        logic [WORD_W-1:0] control_word;
        logic [WORD_W-1:0] current_report;
        logic [WORD_W-1:0] acceptance_report;
        logic              urgent_request;
    } t_in_word;

    typedef struct packed {
        logic [WORD_W-1:0] field_word;
        logic              is_report;
    } t_out_word;

endpackage

@@ sv/ocf_rs_regs.sv @@
// ============================================================================
// ocf_rs_regs
// APB-style register file holding the report interval.
// ============================================================================
module ocf_rs_regs
    import ocf_rs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [PDATA_W-1:0]    pwdata,
    output logic [PDATA_W-1:0]    prdata,
    output logic                  pready,
    output logic [INTERVAL_W-1:0] o_interval
);

    logic [INTERVAL_W-1:0] r_interval;
    logic                  wr_en;
    logic [PADDR_W-3:0]    reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign wr_en   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= INTERVAL_RESET;
        end else if (wr_en && (reg_idx == REG_REPORT_INTERVAL)) begin
            r_interval <= pwdata[INTERVAL_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        unique case (reg_idx)
            REG_REPORT_INTERVAL: prdata = {{(PDATA_W-INTERVAL_W){1'b0}}, r_interval};
            default:             prdata = '0;
        endcase
    end

    assign o_interval = r_interval;

endmodule

@@ sv/ocf_rs_decide.sv @@
// ============================================================================
// ocf_rs_decide
// Selection state and the per-word decision between control word and report.
// ============================================================================
module ocf_rs_decide
    import ocf_rs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_in_word              i_word,
    input  logic [INTERVAL_W-1:0] i_interval,
    input  logic                  i_fire,
    output logic                  o_emit,
    output t_out_word             o_result
);

    logic [WORD_W-1:0]   r_held_acceptance, n_held_acceptance;
    logic                r_acceptance_waiting, n_acceptance_waiting;
    logic                r_report_just_sent, n_report_just_sent;
    logic [BYTE_W-1:0]   r_last_report_byte, n_last_report_byte;
    logic                r_report_byte_valid, n_report_byte_valid;
    logic [STREAK_W-1:0] r_control_streak, n_control_streak;

    logic [BYTE_W-1:0]   low_byte;
    logic                flags;
    logic                changed;
    logic                below;
    logic [STREAK_W-1:0] bumped;

    assign low_byte = i_word.control_word[BYTE_W-1:0];
    assign flags    = |(i_word.control_word & URGENT_FLAG_MASK);
    assign changed  = !r_report_byte_valid || (low_byte != r_last_report_byte);
    assign below    = r_control_streak < i_interval;
    assign bumped   = below ? r_control_streak + STREAK_W'(1) : r_control_streak;
    assign o_emit   = (i_word.func == FUNC_SELECT);

    always_comb begin
        n_held_acceptance    = r_held_acceptance;
        n_acceptance_waiting = r_acceptance_waiting;
        n_report_just_sent   = r_report_just_sent;
        n_last_report_byte   = r_last_report_byte;
        n_report_byte_valid  = r_report_byte_valid;
        n_control_streak     = r_control_streak;
        o_result.field_word  = i_word.control_word;
        o_result.is_report   = 1'b0;
        unique case (i_word.func)
            FUNC_LATCH: begin
                n_held_acceptance    = i_word.acceptance_report;
                n_acceptance_waiting = 1'b1;
            end
            FUNC_CONFIRM: begin
                n_held_acceptance    = '0;
                n_acceptance_waiting = 1'b0;
            end
            FUNC_SELECT: begin
                n_last_report_byte  = low_byte;
                n_report_byte_valid = 1'b1;
                if (r_acceptance_waiting) begin
                    // alternate the pending report with the control word
                    n_report_just_sent = !r_report_just_sent;
                    if (!r_report_just_sent) begin
                        o_result.field_word = r_held_acceptance;
                        o_result.is_report  = 1'b1;
                    end
                end else if (r_report_just_sent || i_word.urgent_request || flags ||
                             changed) begin
                    n_report_just_sent = 1'b0;
                    n_control_streak   = bumped;
                end else if (below) begin
                    n_control_streak = bumped;
                end else begin
                    n_control_streak    = '0;
                    n_report_just_sent  = 1'b1;
                    o_result.field_word = i_word.current_report;
                    o_result.is_report  = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_acceptance    <= '0;
            r_acceptance_waiting <= 1'b0;
            r_report_just_sent   <= 1'b0;
            r_last_report_byte   <= '0;
            r_report_byte_valid  <= 1'b0;
            r_control_streak     <= '0;
        end else if (i_fire) begin
            r_held_acceptance    <= n_held_acceptance;
            r_acceptance_waiting <= n_acceptance_waiting;
            r_report_just_sent   <= n_report_just_sent;
            r_last_report_byte   <= n_last_report_byte;
            r_report_byte_valid  <= n_report_byte_valid;
            r_control_streak     <= n_control_streak;
        end
    end

endmodule

@@ sv/ocf_report_selector_unit.sv @@
// ============================================================================
// ocf_report_selector_unit
// Per-frame choice of control word or security report for the control field.
// ============================================================================
// Input channel: one word per handshake (i_in_valid / o_in_ready) carrying
// func, control word, current report, acceptance report and urgent flag.
// A select word yields one output word (o_out_valid / i_out_ready);
// latch and confirm update state; they and unused codes yield nothing.
// A word is registered at the input, decided by the decision stage and
// its result registered in the result register.
// Throughput: one word per cycle while the output is not stalled, set by
// the single decision stage between the input and result registers.
// When the receiver stalls, the result register holds its word and the
// input register holds the next select; latch and confirm words keep
// flowing past a stalled output since they need no result slot.
// Reset (synchronous, active low) empties both registers, clears the
// selection state and sets the report interval to 4.
// The APB port writes the report interval at byte address 0; pready is
// always high.
// ============================================================================
module ocf_report_selector_unit
    import ocf_rs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  t_in_word           i_in_word,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output t_out_word          o_out_word,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready
);

    logic [INTERVAL_W-1:0] interval;
    logic                  r_in_valid;
    t_in_word              r_in_word;
    logic                  r_out_valid;
    t_out_word             r_out_word;
    t_out_word             result;
    logic                  dec_fire;
    logic                  dec_emit;
    logic                  out_free;

    ocf_rs_regs u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_interval (interval)
    );

    ocf_rs_decide u_decide (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_word     (r_in_word),
        .i_interval (interval),
        .i_fire     (dec_fire),
        .o_emit     (dec_emit),
        .o_result   (result)
    );

    assign out_free   = !r_out_valid || i_out_ready;
    assign dec_fire   = r_in_valid && (!dec_emit || out_free);
    assign o_in_ready = !r_in_valid || dec_fire;

    // input register: advance when empty or when the decision stage takes its word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_word <= i_in_word;
        end
    end

    // result register: load on a select, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (dec_fire && dec_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (dec_fire && dec_emit) begin
            r_out_word <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

endmodule

@@ sv/ocf_rs_checker.sv @@
// ============================================================================
// ocf_rs_checker
// Port-level checks for the report selector, bound to the top level.
// ============================================================================
module ocf_rs_checker
    import ocf_rs_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      o_in_ready,
    input  logic      o_out_valid,
    input  logic      i_out_ready,
    input  t_out_word o_out_word,
    input  logic      pready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out_word))
        else $error("output word changed while stalled");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && pready)
        else $error("output not empty after reset");

endmodule

bind ocf_report_selector_unit ocf_rs_checker u_ocf_rs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_word  (o_out_word),
    .pready      (pready)
);

@@ test/ocf_report_selector_unit_test.sv @@
`timescale 1ns / 1ps
// ============================================================================
// ocf_report_selector_unit_test
// Self-checking bench for the control field report selector. Directed words
// cover the forcing rules, the pending acceptance report, the unused code
// and interval edges. Random frame traffic then runs under three idling
// mixes and several interval settings. A local predictor queues each
// expected field word, and every delivered word is compared against it.
// ============================================================================
module ocf_report_selector_unit_test;
    import ocf_rs_pkg::*;

    localparam logic [PADDR_W-1:0] CFG_ADDR = {REG_REPORT_INTERVAL, 2'b00};

    logic               i_clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    t_in_word           in_word = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    t_out_word          out_word;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [PDATA_W-1:0] pwdata = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;

    ocf_report_selector_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_word   (in_word),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_word  (out_word),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // predictor state
    logic [WORD_W-1:0]     held_acc = '0;
    logic                  acc_pending = 1'b0;
    logic                  report_sent_last = 1'b0;
    logic [BYTE_W-1:0]     last_low_byte = '0;
    logic                  low_byte_seen = 1'b0;
    logic [STREAK_W-1:0]   ctl_streak = '0;
    logic [INTERVAL_W-1:0] cfg_interval = INTERVAL_RESET;

    t_out_word   field_word_q[$];
    logic [7:0]  stream_byte = 8'h00;
    int unsigned send_idle_pct = 0;
    int unsigned recv_idle_pct = 0;
    int unsigned words_sent = 0;
    int unsigned fields_checked = 0;
    int unsigned reports_seen = 0;
    int unsigned interval_writes = 0;
    int unsigned mismatch_count = 0;

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2_400_000;
        $display("FAIL ocf_report_selector_unit");
        $finish;
    end

    always @(negedge i_clk) begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    task automatic note_mismatch(input string what, input logic [WORD_W-1:0] want_v,
                                 input logic [WORD_W-1:0] got_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch %0d: %s expected %h got %h", mismatch_count, what,
                     want_v, got_v);
    endtask

    always @(posedge i_clk) begin : check_fields
        t_out_word want;
        if (rst_n && out_valid && out_ready) begin
            if (field_word_q.size() == 0) begin
                note_mismatch("field word with none pending", '0, out_word.field_word);
            end else begin
                want = field_word_q.pop_front();
                if (want.field_word !== out_word.field_word)
                    note_mismatch("field_word", want.field_word, out_word.field_word);
                if (want.is_report !== out_word.is_report)
                    note_mismatch("is_report", WORD_W'(want.is_report),
                                  WORD_W'(out_word.is_report));
                fields_checked++;
                if (want.is_report)
                    reports_seen++;
            end
        end
    end

    task automatic bump_streak();
        if (ctl_streak < cfg_interval)
            ctl_streak = ctl_streak + 1'b1;
    endtask

    task automatic predict_field_word(input t_in_word w);
        t_out_word r;
        logic      forced;
        logic      byte_changed;
        case (w.func)
            FUNC_LATCH: begin
                held_acc    = w.acceptance_report;
                acc_pending = 1'b1;
            end
            FUNC_CONFIRM: begin
                held_acc    = '0;
                acc_pending = 1'b0;
            end
            FUNC_SELECT: begin
                byte_changed  = !low_byte_seen || (w.control_word[7:0] != last_low_byte);
                forced        = report_sent_last || w.urgent_request || byte_changed
                                || ((w.control_word & URGENT_FLAG_MASK) != '0);
                last_low_byte = w.control_word[7:0];
                low_byte_seen = 1'b1;
                if (acc_pending) begin
                    if (report_sent_last) begin
                        report_sent_last = 1'b0;
                        r = {w.control_word, 1'b0};
                    end else begin
                        report_sent_last = 1'b1;
                        r = {held_acc, 1'b1};
                    end
                end else if (forced || ctl_streak < cfg_interval) begin
                    report_sent_last = 1'b0;
                    bump_streak();
                    r = {w.control_word, 1'b0};
                end else begin
                    ctl_streak       = '0;
                    report_sent_last = 1'b1;
                    r = {w.current_report, 1'b1};
                end
                field_word_q.push_back(r);
            end
            default: ;
        endcase
    endtask

    task automatic send_word(input t_in_word w);
        @(negedge i_clk);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(negedge i_clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge i_clk);
        while (!in_ready)
            @(posedge i_clk);
        predict_field_word(w);
        words_sent++;
    endtask

    function automatic t_in_word mk_word(input t_func f, input logic [WORD_W-1:0] cw,
                                         input logic [WORD_W-1:0] cur,
                                         input logic [WORD_W-1:0] acc, input logic urg);
        t_in_word w;
        w.func              = f;
        w.control_word      = cw;
        w.current_report    = cur;
        w.acceptance_report = acc;
        w.urgent_request    = urg;
        return w;
    endfunction

    // drop valid, wait out pending results, then let in-flight words settle
    task automatic hold_until_drained(input int settle);
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (field_word_q.size() != 0)
            @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_interval(input int value);
        logic [INTERVAL_W-1:0] v;
        v = INTERVAL_W'(value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= CFG_ADDR;
        pwdata  <= {{(PDATA_W-INTERVAL_W){1'b0}}, v};
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        cfg_interval = v;
        interval_writes++;
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready)
            @(posedge i_clk);
        if (prdata[INTERVAL_W-1:0] !== v)
            note_mismatch("report_interval readback", WORD_W'(v),
                          WORD_W'(prdata[INTERVAL_W-1:0]));
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    function automatic t_in_word random_frame_word();
        t_in_word    w;
        int unsigned r;
        r = $urandom_range(0, 99);
        w.control_word      = $urandom;
        w.current_report    = $urandom;
        w.acceptance_report = $urandom;
        w.urgent_request    = ($urandom_range(0, 19) == 0);
        if (r < 7)
            w.func = FUNC_LATCH;
        else if (r < 14)
            w.func = FUNC_CONFIRM;
        else if (r < 17)
            w.func = FUNC_NONE;
        else
            w.func = FUNC_SELECT;
        if ($urandom_range(0, 9) < 8) begin
            w.control_word[7:0] = stream_byte;
            if ($urandom_range(0, 9) != 0)
                w.control_word[13:11] = 3'b000;
        end else begin
            stream_byte = w.control_word[7:0];
        end
        return w;
    endfunction

    task automatic test_select_rules();
        send_word(mk_word(FUNC_SELECT, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0, 1'b0));
        repeat (5)
            send_word(mk_word(FUNC_SELECT, 32'hFFFF_C700, 32'h1234_5678, 32'h0, 1'b0));
        send_word(mk_word(FUNC_SELECT, 32'h0000_0800, 32'h8765_4321, 32'h0, 1'b0));
        send_word(mk_word(FUNC_SELECT, 32'h0000_2000, 32'h8765_4321, 32'h0, 1'b0));
        send_word(mk_word(FUNC_SELECT, 32'h0000_0000, 32'h8765_4321, 32'h0, 1'b1));
        send_word(mk_word(FUNC_SELECT, 32'hFFFF_FFFF, 32'h0000_0000, 32'h0, 1'b0));
    endtask

    task automatic test_acceptance_report();
        send_word(mk_word(FUNC_CONFIRM, 32'h0, 32'h0, 32'hDEAD_BEEF, 1'b0));
        send_word(mk_word(FUNC_NONE, 32'hFFFF_FF00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
        send_word(mk_word(FUNC_LATCH, 32'h0, 32'h0, 32'hA5A5_5A5A, 1'b0));
        send_word(mk_word(FUNC_LATCH, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b0));
        send_word(mk_word(FUNC_SELECT, 32'h0000_00FF, 32'h1111_1111, 32'h0, 1'b0));
        send_word(mk_word(FUNC_SELECT, 32'h0000_0011, 32'h2222_2222, 32'h0, 1'b0));
        send_word(mk_word(FUNC_CONFIRM, 32'h0, 32'h0, 32'h0, 1'b0));
        send_word(mk_word(FUNC_SELECT, 32'h0000_0011, 32'h3333_3333, 32'h0, 1'b0));
    endtask

    task automatic test_interval_edges();
        hold_until_drained(4);
        write_interval(200);
        repeat (5)
            send_word(mk_word(FUNC_SELECT, 32'h0000_0022, 32'h4444_4444, 32'h0, 1'b0));
        hold_until_drained(4);
        write_interval(2);
        send_word(mk_word(FUNC_SELECT, 32'h0000_0022, 32'h5555_5555, 32'h0, 1'b0));
        hold_until_drained(4);
        write_interval(0);
        repeat (3)
            send_word(mk_word(FUNC_SELECT, 32'h0000_0022, 32'h6666_6666, 32'h0, 1'b0));
    endtask

    task automatic test_random_traffic(input int unsigned s_pct, input int unsigned r_pct,
                                       input int first_interval, input int second_interval);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        hold_until_drained(4);
        write_interval(first_interval);
        repeat (37)
            send_word(random_frame_word());
        hold_until_drained(0);
        repeat (38)
            send_word(random_frame_word());
        hold_until_drained(4);
        write_interval(second_interval);
        repeat (75)
            send_word(random_frame_word());
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;
        send_idle_pct = 38;
        recv_idle_pct = 55;
        test_select_rules();
        test_acceptance_report();
        test_interval_edges();
        test_random_traffic(38, 55, 255, 3);
        test_random_traffic(55, 38, 1, 6);
        test_random_traffic(0, 0, $urandom_range(0, 10), 4);
        hold_until_drained(8);
        $display("Sent %0d words across %0d interval settings under three idling mixes.",
                 words_sent, interval_writes);
        $display("Checked %0d field words, %0d of them reports; %0d mismatches.",
                 fields_checked, reports_seen, mismatch_count);
        if (mismatch_count == 0)
            $display("PASS ocf_report_selector_unit");
        else
            $display("FAIL ocf_report_selector_unit");
        $finish;
    end

endmodule

@@ sim.f @@
sv/ocf_rs_pkg.sv
sv/ocf_rs_regs.sv
sv/ocf_rs_decide.sv
sv/ocf_report_selector_unit.sv
sv/ocf_rs_checker.sv
test/ocf_report_selector_unit_test.sv
